// File: hw/rtl/kcl_pkg.sv
package kcl_pkg;

	localparam int KeyW      = 4;
	localparam int LimitW    = 3;
	localparam int TicksW    = 9;
	localparam int FailW     = 3;
	localparam int KeysOutW  = 3;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 24;

	localparam logic [FailW-1:0]  FailMax   = 3'd7;
	localparam logic [FailW-1:0]  FailReset = 3'd1;
	localparam logic [LimitW-1:0] LimitReset = 3'd5;
	localparam logic [TicksW-1:0] TicksReset = 9'd301;
	localparam logic [KeyW-1:0]   CodeBase   = 4'hA;

	typedef enum logic [KeyW-1:0] {
		KEY_STAR = 4'd14,
		KEY_HASH = 4'd15
	} key_code_t;

	typedef enum logic [0:0] {
		FUNC_KEY  = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		PH_OPEN   = 2'd0,
		PH_OLD    = 2'd1,
		PH_NEW    = 2'd2,
		PH_REPEAT = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE         = 4'd0,
		EV_ACCEPTED     = 4'd1,
		EV_REJECTED     = 4'd2,
		EV_LOCK_START   = 4'd3,
		EV_LOCK_END     = 4'd4,
		EV_RELOCKED     = 4'd5,
		EV_CHANGE_START = 4'd6,
		EV_OLD_WRONG    = 4'd7,
		EV_CHANGED      = 4'd8,
		EV_REFUSED      = 4'd9
	} event_t;

	typedef enum logic [0:0] {
		CFG_FAIL_LIMIT    = 1'b0,
		CFG_LOCKOUT_TICKS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		func_t           func;
		logic [KeyW-1:0] key_value;
	} kcl_item_t;

	typedef struct packed {
		event_t              event_res;
		phase_t              entry_phase;
		logic [KeysOutW-1:0] keys_entered;
		logic [TicksW-1:0]   seconds_left;
		logic                locked_out;
		logic                unlocked;
	} kcl_result_t;

endpackage

// File: hw/rtl/kcl_ctrl.sv
module kcl_ctrl import kcl_pkg::*; #(
	parameter int CODE_LENGTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  kcl_item_t         item,
	input  logic [LimitW-1:0] fail_limit,
	input  logic [TicksW-1:0] lockout_ticks,
	output kcl_result_t       result
);

	localparam int CntW = $clog2(CODE_LENGTH + 1);

	logic [KeyW-1:0]   stored_q  [CODE_LENGTH];
	logic [KeyW-1:0]   entry_q   [CODE_LENGTH];
	logic [KeyW-1:0]   pending_q [CODE_LENGTH];
	logic [KeyW-1:0]   entry_nx  [CODE_LENGTH];
	logic [CntW-1:0]   count_q, count_d, count_inc;
	phase_t            phase_q, phase_d;
	logic [FailW-1:0]  fail_q, fail_d, fail_inc;
	logic [TicksW-1:0] lock_q, lock_d, lock_dec;
	logic              open_q, open_d;
	logic              entry_we, pending_we, stored_we;
	logic              match_stored, match_pending, last_key;
	event_t            ev;

	// Entry as it stands with the current key placed at its slot.
	always_comb begin
		match_stored  = 1'b1;
		match_pending = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			entry_nx[i] = (count_q == CntW'(i)) ? item.key_value : entry_q[i];
			if (entry_nx[i] != stored_q[i])
				match_stored = 1'b0;
			if (entry_nx[i] != pending_q[i])
				match_pending = 1'b0;
		end
	end

	assign count_inc = count_q + CntW'(1);
	assign last_key  = (count_inc == CntW'(CODE_LENGTH));
	assign fail_inc  = (fail_q < FailMax) ? fail_q + FailW'(1) : fail_q;
	assign lock_dec  = lock_q - TicksW'(1);

	always_comb begin
		count_d    = count_q;
		phase_d    = phase_q;
		fail_d     = fail_q;
		lock_d     = lock_q;
		open_d     = open_q;
		entry_we   = 1'b0;
		pending_we = 1'b0;
		stored_we  = 1'b0;
		ev         = EV_NONE;
		if (item.func == FUNC_TICK) begin
			if (lock_q != '0) begin
				lock_d = lock_dec;
				if (lock_dec == '0) begin
					fail_d = '0;
					ev     = EV_LOCK_END;
				end
			end
		end else if (lock_q != '0) begin
			ev = EV_NONE;
		end else if (open_q) begin
			open_d  = 1'b0;
			count_d = '0;
			phase_d = PH_OPEN;
			ev      = EV_RELOCKED;
		end else if (item.key_value == KEY_HASH) begin
			ev = EV_NONE;
		end else if (item.key_value == KEY_STAR) begin
			phase_d = PH_OLD;
			count_d = '0;
			ev      = EV_CHANGE_START;
		end else begin
			entry_we = 1'b1;
			count_d  = count_inc;
			if (last_key) begin
				count_d = '0;
				unique case (phase_q)
					PH_OPEN: begin
						if (match_stored) begin
							open_d = 1'b1;
							fail_d = '0;
							ev     = EV_ACCEPTED;
						end else if (fail_inc >= fail_limit) begin
							lock_d = lockout_ticks;
							fail_d = (lockout_ticks == '0) ? '0 : fail_inc;
							ev     = EV_LOCK_START;
						end else begin
							fail_d = fail_inc;
							ev     = EV_REJECTED;
						end
					end
					PH_OLD: begin
						phase_d = match_stored ? PH_NEW : PH_OPEN;
						ev      = match_stored ? EV_ACCEPTED : EV_OLD_WRONG;
					end
					PH_NEW: begin
						pending_we = 1'b1;
						phase_d    = PH_REPEAT;
					end
					PH_REPEAT: begin
						stored_we = match_pending;
						phase_d   = PH_OPEN;
						ev        = match_pending ? EV_CHANGED : EV_REFUSED;
					end
					default: phase_d = PH_OPEN;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= PH_OPEN;
			fail_q  <= FailReset;
			lock_q  <= '0;
			open_q  <= 1'b0;
			for (int i = 0; i < CODE_LENGTH; i++)
				stored_q[i] <= CodeBase + KeyW'(i % 4);
		end else if (step) begin
			count_q <= count_d;
			phase_q <= phase_d;
			fail_q  <= fail_d;
			lock_q  <= lock_d;
			open_q  <= open_d;
			if (stored_we)
				for (int i = 0; i < CODE_LENGTH; i++)
					stored_q[i] <= entry_nx[i];
		end
	end

	always_ff @(posedge clk) begin
		if (step && entry_we)
			for (int i = 0; i < CODE_LENGTH; i++)
				entry_q[i] <= entry_nx[i];
		if (step && pending_we)
			for (int i = 0; i < CODE_LENGTH; i++)
				pending_q[i] <= entry_nx[i];
	end

	always_comb begin
		result.unlocked     = open_d;
		result.locked_out   = (lock_d != '0);
		result.seconds_left = lock_d;
		result.keys_entered = KeysOutW'(count_d);
		result.entry_phase  = phase_d;
		result.event_res    = ev;
	end

endmodule

// File: hw/rtl/keypad_code_lock.sv
// Keypad code lock.
// Input items arrive on the s_ stream: s_tuser[0] is 0 for a key press and 1
// for a one-second tick, s_tdata[3:0] is the key (digits, A-D, star, hash).
// Every accepted item yields exactly one result item on the m_ stream, which
// shows the lock state after that item plus an event code.
// Configuration goes through the cfg_ write channel (index 0 = failure
// limit, index 1 = lockout length in ticks); it is always ready and should
// only be used while no item is in flight.
// After acceptance the item sits in the input register, then the state update
// loads the result into the output register, where it stays valid until taken.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single state-update step per item.
// Reset loads the default code A,B,C,D, a failure count of one, a failure
// limit of five and a lockout length of 301 ticks, and empties both stages.
// When the receiver stalls, the result stays in the output register, the
// input register fills, and s_tready drops until the result is taken.
module keypad_code_lock import kcl_pkg::*; #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // key_value[3:0], zero fill
	input  logic [0:0]          s_tuser,   // func[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	// unlocked[0], locked_out[1], seconds_left[10:2], keys_entered[13:11],
	// entry_phase[15:14], event_res[19:16], zero fill
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfg_index_t          cfg_index,
	input  logic [TicksW-1:0]   cfg_data
);

	logic              valid_s1;
	kcl_item_t         item_s1;
	logic              fire;
	logic              m_tvalid_q;
	kcl_result_t       result_q, result_d;
	logic [LimitW-1:0] fail_limit_q;
	logic [TicksW-1:0] lockout_ticks_q;

	assign fire      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q    <= LimitReset;
			lockout_ticks_q <= TicksReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FAIL_LIMIT:    fail_limit_q    <= cfg_data[LimitW-1:0];
				CFG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (fire)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func      <= func_t'(s_tuser[0]);
			item_s1.key_value <= s_tdata[KeyW-1:0];
		end
		if (fire)
			result_q <= result_d;
	end

	kcl_ctrl #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (fire),
		.item         (item_s1),
		.fail_limit   (fail_limit_q),
		.lockout_ticks(lockout_ticks_q),
		.result       (result_d)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(result_q);

	// The lockout flag and the remaining tick count must agree.
	a_lock_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (result_q.locked_out == (result_q.seconds_left != '0)))
		else $error("locked_out disagrees with seconds_left");

	// The lock never opens while a lockout runs.
	a_open_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(result_q.unlocked && result_q.locked_out))
		else $error("lock open during lockout");

	// A full entry is always consumed in the same step.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (32'(result_q.keys_entered) < CODE_LENGTH))
		else $error("key count reached the code length");

	// With the output register empty the input side must not stall.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid_q |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
